// File: rtl/rbrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrf_pkg: shared types and constants of the record byte ring FIFO
// Ring geometry, action and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rbrf_pkg;

	// Ring geometry. The pointers carry one bit more than the index so that
	// a full ring and an empty ring can be told apart.
	localparam int unsigned DEPTH     = 256;
	localparam int unsigned IDX_W     = $clog2(DEPTH);
	localparam int unsigned PTR_W     = IDX_W + 1;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned HDR_BYTES = 2;
	localparam int unsigned REC_MAX   = 65535;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		ACT_PUT,
		ACT_GET,
		ACT_WR_BEGIN,
		ACT_WR_BYTE,
		ACT_RD_BEGIN,
		ACT_RD_BYTE,
		ACT_SKIP,
		ACT_CLEAR
	} action_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_SPACE,
		ST_EMPTY,
		ST_SEQUENCE
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WRITING,
		MODE_READING
	} mode_t;

	// Memory address selection for one access of the single-port ring.
	typedef enum logic [2:0] {
		AS_RP,
		AS_RP1,
		AS_RD_BODY,
		AS_WP,
		AS_WP1,
		AS_WR_BODY
	} addr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      mem_rd;
		logic      mem_wr;
		addr_sel_t sel;
		logic      hdr_lo;
		logic      commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;
		logic    ok;
	} dp_sts_t;

endpackage

// File: rtl/rbrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrf_if: request and response channels of the record byte ring FIFO
// Valid and ready handshake; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface rbrf_req_if;
	logic                         valid;
	logic                         ready;
	logic [2:0]                   action;
	logic [rbrf_pkg::BYTE_W-1:0]  data_in;
	logic [rbrf_pkg::LEN_W-1:0]   length;

	modport source(output valid, output action, output data_in, output length, input ready);
	modport sink(input valid, input action, input data_in, input length, output ready);
endinterface

interface rbrf_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rbrf_pkg::BYTE_W-1:0]  data_out;
	logic [1:0]                   status;
	logic [rbrf_pkg::LEN_W-1:0]   record_length;
	logic                         last;
	logic [rbrf_pkg::PTR_W-1:0]   fill_level;
	logic                         empty_res;
	logic [rbrf_pkg::LEN_W-1:0]   record_space;

	modport source(output valid, output data_out, output status, output record_length,
		output last, output fill_level, output empty_res, output record_space, input ready);
	modport sink(input valid, input data_out, input status, input record_length,
		input last, input fill_level, input empty_res, input record_space, output ready);
endinterface

// File: rtl/rbrf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrf_ctrl: sequencer of the record byte ring FIFO
// Accepts one transaction at a time, orders the accesses to the single-port
// ring memory and commits the result into the response register.
// ----------------------------------------------------------------------------
module rbrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  rbrf_pkg::dp_sts_t sts,
	output rbrf_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_HDR1,
		S_HDR2,
		S_WR_HI,
		S_RD_WAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	// The response register may be loaded when empty or being emptied.
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.ok) begin
					cmd.commit = out_free;
					if (out_free) state_d = S_IDLE;
				end else begin
					case (sts.action)
						rbrf_pkg::ACT_PUT: begin
							cmd.mem_wr = 1'b1;
							cmd.sel    = rbrf_pkg::AS_WP;
							cmd.commit = out_free;
							if (out_free) state_d = S_IDLE;
						end
						rbrf_pkg::ACT_WR_BYTE: begin
							cmd.mem_wr = 1'b1;
							cmd.sel    = rbrf_pkg::AS_WR_BODY;
							cmd.commit = out_free;
							if (out_free) state_d = S_IDLE;
						end
						rbrf_pkg::ACT_WR_BEGIN: begin
							cmd.mem_wr = 1'b1;
							cmd.sel    = rbrf_pkg::AS_WP;
							state_d    = S_WR_HI;
						end
						rbrf_pkg::ACT_GET: begin
							cmd.mem_rd = 1'b1;
							cmd.sel    = rbrf_pkg::AS_RP;
							state_d    = S_RD_WAIT;
						end
						rbrf_pkg::ACT_RD_BYTE: begin
							cmd.mem_rd = 1'b1;
							cmd.sel    = rbrf_pkg::AS_RD_BODY;
							state_d    = S_RD_WAIT;
						end
						rbrf_pkg::ACT_RD_BEGIN, rbrf_pkg::ACT_SKIP: begin
							cmd.mem_rd = 1'b1;
							cmd.sel    = rbrf_pkg::AS_RP;
							state_d    = S_HDR1;
						end
						default: begin
							cmd.commit = out_free;
							if (out_free) state_d = S_IDLE;
						end
					endcase
				end
			end
			S_HDR1: begin
				// The low header byte is in the read register; fetch the high one.
				cmd.hdr_lo = 1'b1;
				cmd.mem_rd = 1'b1;
				cmd.sel    = rbrf_pkg::AS_RP1;
				state_d    = S_HDR2;
			end
			S_HDR2, S_RD_WAIT: begin
				cmd.commit = out_free;
				if (out_free) state_d = S_IDLE;
			end
			S_WR_HI: begin
				cmd.mem_wr = 1'b1;
				cmd.sel    = rbrf_pkg::AS_WP1;
				cmd.commit = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and response valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/rbrf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrf_dp: datapath of the record byte ring FIFO
// Holds the ring memory, the pointers and record counters, checks each
// transaction against the ring state and forms the response fields.
// ----------------------------------------------------------------------------
module rbrf_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rbrf_pkg::dp_cmd_t            cmd,
	output rbrf_pkg::dp_sts_t            sts,
	input  logic [2:0]                   action,
	input  logic [rbrf_pkg::BYTE_W-1:0]  data_in,
	input  logic [rbrf_pkg::LEN_W-1:0]   length,
	output logic [rbrf_pkg::BYTE_W-1:0]  data_out,
	output logic [1:0]                   status,
	output logic [rbrf_pkg::LEN_W-1:0]   record_length,
	output logic                         last,
	output logic [rbrf_pkg::PTR_W-1:0]   fill_level,
	output logic                         empty_res,
	output logic [rbrf_pkg::LEN_W-1:0]   record_space
);

	localparam int unsigned PTR_W  = rbrf_pkg::PTR_W;
	localparam int unsigned IDX_W  = rbrf_pkg::IDX_W;
	localparam int unsigned LEN_W  = rbrf_pkg::LEN_W;
	localparam int unsigned BYTE_W = rbrf_pkg::BYTE_W;
	localparam int unsigned WIDE_W = LEN_W + 1;
	localparam rbrf_pkg::ptr_t DEPTH_P = PTR_W'(rbrf_pkg::DEPTH);
	localparam rbrf_pkg::ptr_t HDR_P   = PTR_W'(rbrf_pkg::HDR_BYTES);
	localparam logic [WIDE_W-1:0] HDR_W   = WIDE_W'(rbrf_pkg::HDR_BYTES);
	localparam logic [WIDE_W-1:0] RECMX_W = WIDE_W'(rbrf_pkg::REC_MAX);

	// Latched transaction.
	rbrf_pkg::action_t     act_q;
	logic [BYTE_W-1:0]     din_q;
	logic [LEN_W-1:0]      len_q;

	// Ring state.
	logic [BYTE_W-1:0]     ring_mem_q [rbrf_pkg::DEPTH];
	logic [BYTE_W-1:0]     rdata_q;
	logic [BYTE_W-1:0]     hdr_lo_q;
	rbrf_pkg::ptr_t        wp_q, wp_d;
	rbrf_pkg::ptr_t        rp_q, rp_d;
	logic [LEN_W-1:0]      body_left_q, body_left_d;
	logic [LEN_W-1:0]      wr_off_q, wr_off_d;
	logic [LEN_W-1:0]      rd_off_q, rd_off_d;
	logic [LEN_W-1:0]      rd_want_q, rd_want_d;
	logic [LEN_W-1:0]      head_len_q, head_len_d;
	rbrf_pkg::mode_t       mode_q, mode_d;

	// Response register.
	logic [BYTE_W-1:0]     data_out_q, dout_d;
	rbrf_pkg::status_t     status_q, status_c;
	logic [LEN_W-1:0]      rlen_q, rlen_d;
	logic                  last_q, last_d;

	// Derived values.
	rbrf_pkg::ptr_t        fill;
	rbrf_pkg::ptr_t        unused;
	rbrf_pkg::ptr_t        avail;
	logic [WIDE_W-1:0]     space_w;
	logic [LEN_W-1:0]      hdr;
	logic [LEN_W-1:0]      body;
	logic [LEN_W-1:0]      cnt;
	logic [LEN_W-1:0]      wr_off_inc;
	logic [LEN_W-1:0]      left_dec;
	logic [LEN_W-1:0]      rd_off_inc;
	rbrf_pkg::ptr_t        addr;
	logic [BYTE_W-1:0]     wdata;

	assign fill    = wp_q - rp_q;
	assign unused  = DEPTH_P - fill;
	assign avail   = fill - HDR_P;
	assign space_w = WIDE_W'(unused) - HDR_W;
	assign hdr     = {rdata_q, hdr_lo_q};

	// Header length cut to the committed bytes behind it, and bytes to return.
	assign body = ({1'b0, hdr} < WIDE_W'(avail)) ? hdr : LEN_W'(avail);
	assign cnt  = (len_q < body) ? len_q : body;

	assign wr_off_inc = wr_off_q + LEN_W'(1);
	assign left_dec   = (body_left_q != '0) ? body_left_q - LEN_W'(1) : '0;
	assign rd_off_inc = rd_off_q + LEN_W'(1);

	// Check the transaction against the mode and the fill.
	always_comb begin
		status_c = rbrf_pkg::ST_OK;
		case (act_q)
			rbrf_pkg::ACT_CLEAR: begin
				status_c = rbrf_pkg::ST_OK;
			end
			rbrf_pkg::ACT_WR_BYTE: begin
				if (mode_q != rbrf_pkg::MODE_WRITING) status_c = rbrf_pkg::ST_SEQUENCE;
			end
			rbrf_pkg::ACT_RD_BYTE: begin
				if (mode_q != rbrf_pkg::MODE_READING) status_c = rbrf_pkg::ST_SEQUENCE;
			end
			default: begin
				if (mode_q != rbrf_pkg::MODE_IDLE) begin
					status_c = rbrf_pkg::ST_SEQUENCE;
				end else begin
					case (act_q)
						rbrf_pkg::ACT_PUT: begin
							if (fill == DEPTH_P) status_c = rbrf_pkg::ST_NO_SPACE;
						end
						rbrf_pkg::ACT_GET: begin
							if (fill == '0) status_c = rbrf_pkg::ST_EMPTY;
						end
						rbrf_pkg::ACT_WR_BEGIN: begin
							if (({1'b0, len_q} + HDR_W) > WIDE_W'(unused)) begin
								status_c = rbrf_pkg::ST_NO_SPACE;
							end
						end
						rbrf_pkg::ACT_RD_BEGIN, rbrf_pkg::ACT_SKIP: begin
							if (fill < HDR_P) status_c = rbrf_pkg::ST_EMPTY;
						end
						default: begin
							status_c = rbrf_pkg::ST_OK;
						end
					endcase
				end
			end
		endcase
	end

	assign sts.action = act_q;
	assign sts.ok     = (status_c == rbrf_pkg::ST_OK);

	// State update and response fields of a successful transaction.
	always_comb begin
		wp_d        = wp_q;
		rp_d        = rp_q;
		body_left_d = body_left_q;
		wr_off_d    = wr_off_q;
		rd_off_d    = rd_off_q;
		rd_want_d   = rd_want_q;
		head_len_d  = head_len_q;
		mode_d      = mode_q;
		dout_d      = '0;
		rlen_d      = '0;
		last_d      = 1'b0;
		if (status_c == rbrf_pkg::ST_OK) begin
			case (act_q)
				rbrf_pkg::ACT_PUT: begin
					wp_d = wp_q + PTR_W'(1);
				end
				rbrf_pkg::ACT_GET: begin
					dout_d = rdata_q;
					rp_d   = rp_q + PTR_W'(1);
				end
				rbrf_pkg::ACT_WR_BEGIN: begin
					body_left_d = len_q;
					wr_off_d    = '0;
					if (len_q == '0) begin
						wp_d = wp_q + HDR_P;
					end else begin
						mode_d = rbrf_pkg::MODE_WRITING;
					end
				end
				rbrf_pkg::ACT_WR_BYTE: begin
					wr_off_d    = wr_off_inc;
					body_left_d = left_dec;
					if (left_dec == '0) begin
						// Last body byte: the record becomes visible.
						wp_d     = wp_q + HDR_P + PTR_W'(wr_off_inc);
						wr_off_d = '0;
						mode_d   = rbrf_pkg::MODE_IDLE;
					end
				end
				rbrf_pkg::ACT_RD_BEGIN: begin
					rlen_d = hdr;
					if (cnt == '0) begin
						rp_d = rp_q + HDR_P + PTR_W'(body);
					end else begin
						head_len_d = body;
						rd_want_d  = cnt;
						rd_off_d   = '0;
						mode_d     = rbrf_pkg::MODE_READING;
					end
				end
				rbrf_pkg::ACT_RD_BYTE: begin
					dout_d   = rdata_q;
					rd_off_d = rd_off_inc;
					if (rd_off_inc >= rd_want_q) begin
						// Final byte wanted: drop the rest of the record.
						last_d    = 1'b1;
						rp_d      = rp_q + HDR_P + PTR_W'(head_len_q);
						rd_off_d  = '0;
						rd_want_d = '0;
						mode_d    = rbrf_pkg::MODE_IDLE;
					end
				end
				rbrf_pkg::ACT_SKIP: begin
					rlen_d = hdr;
					rp_d   = rp_q + HDR_P + PTR_W'(body);
				end
				rbrf_pkg::ACT_CLEAR: begin
					wp_d        = '0;
					rp_d        = '0;
					body_left_d = '0;
					wr_off_d    = '0;
					rd_off_d    = '0;
					rd_want_d   = '0;
					head_len_d  = '0;
					mode_d      = rbrf_pkg::MODE_IDLE;
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
	end

	// Memory address and write data.
	always_comb begin
		wdata = din_q;
		case (cmd.sel)
			rbrf_pkg::AS_RP:      addr = rp_q;
			rbrf_pkg::AS_RP1:     addr = rp_q + PTR_W'(1);
			rbrf_pkg::AS_RD_BODY: addr = rp_q + HDR_P + PTR_W'(rd_off_q);
			rbrf_pkg::AS_WP: begin
				addr = wp_q;
				if (act_q == rbrf_pkg::ACT_WR_BEGIN) wdata = len_q[BYTE_W-1:0];
			end
			rbrf_pkg::AS_WP1: begin
				addr  = wp_q + PTR_W'(1);
				wdata = len_q[LEN_W-1:BYTE_W];
			end
			rbrf_pkg::AS_WR_BODY: addr = wp_q + HDR_P + PTR_W'(wr_off_q);
			default:              addr = wp_q;
		endcase
	end

	// Single-port ring memory with registered read data.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			ring_mem_q[addr[IDX_W-1:0]] <= wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= ring_mem_q[addr[IDX_W-1:0]];
		end
	end

	// Transaction latch, header low byte and response payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= rbrf_pkg::action_t'(action);
			din_q <= data_in;
			len_q <= length;
		end
		if (cmd.hdr_lo) begin
			hdr_lo_q <= rdata_q;
		end
		if (cmd.commit) begin
			data_out_q <= dout_d;
			status_q   <= status_c;
			rlen_q     <= rlen_d;
			last_q     <= last_d;
		end
	end

	// Pointers, counters and mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			body_left_q <= '0;
			wr_off_q    <= '0;
			rd_off_q    <= '0;
			rd_want_q   <= '0;
			head_len_q  <= '0;
			mode_q      <= rbrf_pkg::MODE_IDLE;
		end else if (cmd.commit) begin
			wp_q        <= wp_d;
			rp_q        <= rp_d;
			body_left_q <= body_left_d;
			wr_off_q    <= wr_off_d;
			rd_off_q    <= rd_off_d;
			rd_want_q   <= rd_want_d;
			head_len_q  <= head_len_d;
			mode_q      <= mode_d;
		end
	end

	// The ring state only moves on a commit, so the level fields of the
	// pending response follow the pointers directly.
	always_comb begin
		if (unused <= HDR_P) begin
			record_space = '0;
		end else if (space_w > RECMX_W) begin
			record_space = LEN_W'(rbrf_pkg::REC_MAX);
		end else begin
			record_space = space_w[LEN_W-1:0];
		end
	end

	assign data_out      = data_out_q;
	assign status        = status_q;
	assign record_length = rlen_q;
	assign last          = last_q;
	assign fill_level    = fill;
	assign empty_res     = (wp_q == rp_q);

endmodule

// File: rtl/record_byte_ring_fifo.sv
`timescale 1ns / 1ps
// A request is latched, then executed: put, write byte, clear and refused actions commit
// there, get and read byte after a read wait, record write begin after the high header write,
// read begin and skip after both header reads. One transaction at a time; the single-port ring
// memory and its registered read set these steps. A finished response waits in its register
// while the next request is taken, and a stalled response holds back the next commit.
// Reset clears pointers, counters and mode at once; the ring memory is kept.
// ----------------------------------------------------------------------------
// record_byte_ring_fifo: byte ring FIFO with length-prefixed records
// Power-of-two byte ring with plain byte put and get, and record write,
// read, skip and clear, one byte per transaction.
// ----------------------------------------------------------------------------
module record_byte_ring_fifo (
	input  logic       clk,
	input  logic       arst_n,
	rbrf_req_if.sink   req,
	rbrf_rsp_if.source rsp
);

	rbrf_pkg::dp_cmd_t cmd;
	rbrf_pkg::dp_sts_t sts;
	logic              req_ready;
	logic              rsp_valid;

	// Sequencer.
	rbrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Ring memory and state.
	rbrf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (req.action),
		.data_in       (req.data_in),
		.length        (req.length),
		.data_out      (rsp.data_out),
		.status        (rsp.status),
		.record_length (rsp.record_length),
		.last          (rsp.last),
		.fill_level    (rsp.fill_level),
		.empty_res     (rsp.empty_res),
		.record_space  (rsp.record_space)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

// File: rtl/rbrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrf_checker: port-level checks of the record byte ring FIFO
// Watches the response channel for consistent level fields and status
// encodings, and for a held response while it is stalled.
// ----------------------------------------------------------------------------
module rbrf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [rbrf_pkg::BYTE_W-1:0]  data_out,
	input logic [1:0]                   status,
	input logic [rbrf_pkg::LEN_W-1:0]   record_length,
	input logic                         last,
	input logic [rbrf_pkg::PTR_W-1:0]   fill_level,
	input logic                         empty_res
);

	// The fill never exceeds the ring size.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fill_level <= rbrf_pkg::PTR_W'(rbrf_pkg::DEPTH))
		else $error("fill level beyond ring size");

	// Equal pointers and a zero fill go together.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> empty_res == (fill_level == '0))
		else $error("empty flag disagrees with fill level");

	// The final byte of a record read is a successful read with no header length.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && last |-> status == rbrf_pkg::ST_OK && record_length == '0)
		else $error("last set on a response that is not a record byte");

	// A refused action returns no data, no length and no last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != rbrf_pkg::ST_OK |-> data_out == '0 && record_length == '0 && !last)
		else $error("refused action carries payload");

	// A stalled response holds, including the ring level it reports.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(status)
			&& $stable(fill_level))
		else $error("stalled response changed");

endmodule

bind record_byte_ring_fifo rbrf_checker u_rbrf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.data_out      (rsp.data_out),
	.status        (rsp.status),
	.record_length (rsp.record_length),
	.last          (rsp.last),
	.fill_level    (rsp.fill_level),
	.empty_res     (rsp.empty_res)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for record_byte_ring_fifo
// Drives byte and record actions through the request channel, predicts every
// response with a cycle-free model of the ring and compares each response
// field by field. A short directed run covers the corner cases. It is followed
// by random record and byte traffic under several idling and stalling phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 12;

	localparam int unsigned DEPTH     = rbrf_pkg::DEPTH;
	localparam int unsigned IDX_W     = rbrf_pkg::IDX_W;
	localparam int unsigned PTR_W     = rbrf_pkg::PTR_W;
	localparam int unsigned LEN_W     = rbrf_pkg::LEN_W;
	localparam int unsigned BYTE_W    = rbrf_pkg::BYTE_W;
	localparam int unsigned HDR_BYTES = rbrf_pkg::HDR_BYTES;
	localparam int unsigned REC_MAX   = rbrf_pkg::REC_MAX;

	// One response as the ring is expected to give it.
	typedef struct {
		logic [BYTE_W-1:0]  data_out;
		rbrf_pkg::status_t  status;
		logic [LEN_W-1:0]   record_length;
		logic               last;
		logic [PTR_W-1:0]   fill_level;
		logic               empty_res;
		logic [LEN_W-1:0]   record_space;
	} ring_response_t;

	// Tracks the ring contents and pointers, and queues the responses that
	// accepted requests are due to produce.
	class record_ring_tracker;
		logic [BYTE_W-1:0] ring [DEPTH];
		rbrf_pkg::ptr_t    wr_ptr;
		rbrf_pkg::ptr_t    rd_ptr;
		logic [LEN_W-1:0]  body_left;
		logic [LEN_W-1:0]  wr_off;
		logic [LEN_W-1:0]  rd_off;
		logic [LEN_W-1:0]  rd_want;
		logic [LEN_W-1:0]  head_len;
		rbrf_pkg::mode_t   mode;
		ring_response_t    pending_responses [$];
		int unsigned       mismatches;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			mismatches = 0;
			reset_pointers();
		endfunction

		function void reset_pointers();
			wr_ptr    = '0;
			rd_ptr    = '0;
			body_left = '0;
			wr_off    = '0;
			rd_off    = '0;
			rd_want   = '0;
			head_len  = '0;
			mode      = rbrf_pkg::MODE_IDLE;
		endfunction

		function int unsigned committed();
			rbrf_pkg::ptr_t diff;
			diff = wr_ptr - rd_ptr;
			return int'(diff);
		endfunction

		function int unsigned record_room();
			int unsigned unused;
			unused = DEPTH - committed();
			if (unused <= HDR_BYTES)
				return 0;
			unused = unused - HDR_BYTES;
			return (unused > REC_MAX) ? REC_MAX : unused;
		endfunction

		function int unsigned pending();
			return pending_responses.size();
		endfunction

		// Works out the response to one accepted request and updates the ring.
		function void apply_request(rbrf_pkg::action_t act, logic [BYTE_W-1:0] din,
				logic [LEN_W-1:0] len);
			ring_response_t r;
			int unsigned    hdr;
			int unsigned    body;
			int unsigned    avail;
			int unsigned    cnt;
			r.data_out      = '0;
			r.status        = rbrf_pkg::ST_OK;
			r.record_length = '0;
			r.last          = 1'b0;
			if (act == rbrf_pkg::ACT_CLEAR) begin
				reset_pointers();
			end else if (act == rbrf_pkg::ACT_WR_BYTE) begin
				if (mode != rbrf_pkg::MODE_WRITING) begin
					r.status = rbrf_pkg::ST_SEQUENCE;
				end else begin
					ring[IDX_W'(wr_ptr + HDR_BYTES + wr_off)] = din;
					wr_off++;
					if (body_left > 0)
						body_left--;
					// The record becomes visible with its last body byte.
					if (body_left == 0) begin
						wr_ptr = PTR_W'(wr_ptr + HDR_BYTES + wr_off);
						wr_off = '0;
						mode   = rbrf_pkg::MODE_IDLE;
					end
				end
			end else if (act == rbrf_pkg::ACT_RD_BYTE) begin
				if (mode != rbrf_pkg::MODE_READING) begin
					r.status = rbrf_pkg::ST_SEQUENCE;
				end else begin
					r.data_out = ring[IDX_W'(rd_ptr + HDR_BYTES + rd_off)];
					rd_off++;
					// The final wanted byte drops the whole record.
					if (rd_off >= rd_want) begin
						r.last  = 1'b1;
						rd_ptr  = PTR_W'(rd_ptr + HDR_BYTES + head_len);
						rd_off  = '0;
						rd_want = '0;
						mode    = rbrf_pkg::MODE_IDLE;
					end
				end
			end else if (mode != rbrf_pkg::MODE_IDLE) begin
				r.status = rbrf_pkg::ST_SEQUENCE;
			end else begin
				case (act)
					rbrf_pkg::ACT_PUT: begin
						if (committed() >= DEPTH) begin
							r.status = rbrf_pkg::ST_NO_SPACE;
						end else begin
							ring[IDX_W'(wr_ptr)] = din;
							wr_ptr = wr_ptr + 1'b1;
						end
					end
					rbrf_pkg::ACT_GET: begin
						if (committed() == 0) begin
							r.status = rbrf_pkg::ST_EMPTY;
						end else begin
							r.data_out = ring[IDX_W'(rd_ptr)];
							rd_ptr = rd_ptr + 1'b1;
						end
					end
					rbrf_pkg::ACT_WR_BEGIN: begin
						if (int'(len) + HDR_BYTES > DEPTH - committed()) begin
							r.status = rbrf_pkg::ST_NO_SPACE;
						end else begin
							ring[IDX_W'(wr_ptr)]     = len[7:0];
							ring[IDX_W'(wr_ptr + 1)] = len[15:8];
							wr_off    = '0;
							body_left = len;
							if (len == 0)
								wr_ptr = PTR_W'(wr_ptr + HDR_BYTES);
							else
								mode = rbrf_pkg::MODE_WRITING;
						end
					end
					default: begin
						// Read begin and skip both look at the head record.
						if (committed() < HDR_BYTES) begin
							r.status = rbrf_pkg::ST_EMPTY;
						end else begin
							hdr   = {ring[IDX_W'(rd_ptr + 1)], ring[IDX_W'(rd_ptr)]};
							avail = committed() - HDR_BYTES;
							body  = (hdr < avail) ? hdr : avail;
							r.record_length = hdr[LEN_W-1:0];
							cnt = (len < body) ? len : body;
							if (act == rbrf_pkg::ACT_SKIP || cnt == 0) begin
								rd_ptr = PTR_W'(rd_ptr + HDR_BYTES + body);
							end else begin
								head_len = body[LEN_W-1:0];
								rd_want  = cnt[LEN_W-1:0];
								rd_off   = '0;
								mode     = rbrf_pkg::MODE_READING;
							end
						end
					end
				endcase
			end
			r.fill_level   = PTR_W'(committed());
			r.empty_res    = (wr_ptr == rd_ptr);
			r.record_space = LEN_W'(record_room());
			pending_responses.push_back(r);
		endfunction

		function void compare_field(string name, logic [LEN_W-1:0] want,
				logic [LEN_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compares one received response with the oldest one outstanding.
		function void check_response(ring_response_t got);
			ring_response_t want;
			if (pending_responses.size() == 0) begin
				$error("response received with no request outstanding");
				mismatches++;
				return;
			end
			want = pending_responses.pop_front();
			compare_field("data_out", LEN_W'(want.data_out), LEN_W'(got.data_out));
			compare_field("status", LEN_W'(want.status), LEN_W'(got.status));
			compare_field("record_length", want.record_length, got.record_length);
			compare_field("last", LEN_W'(want.last), LEN_W'(got.last));
			compare_field("fill_level", LEN_W'(want.fill_level), LEN_W'(got.fill_level));
			compare_field("empty_res", LEN_W'(want.empty_res), LEN_W'(got.empty_res));
			compare_field("record_space", want.record_space, got.record_space);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	int unsigned        idle_pct;
	int unsigned        stall_pct;
	int unsigned        items_sent;
	int unsigned        quiet_cycles;
	record_ring_tracker tracker = new();

	rbrf_req_if req ();
	rbrf_rsp_if rsp ();

	record_byte_ring_fifo dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Clock generation.
	always #4 clk = ~clk;

	// Random payload values.
	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		return LEN_W'($urandom_range(65535));
	endfunction

	// Response side: check each completed transaction, then stall at random.
	always @(posedge clk) begin
		ring_response_t got;
		if (rsp.valid && rsp.ready) begin
			got.data_out      = rsp.data_out;
			got.status        = rbrf_pkg::status_t'(rsp.status);
			got.record_length = rsp.record_length;
			got.last          = rsp.last;
			got.fill_level    = rsp.fill_level;
			got.empty_res     = rsp.empty_res;
			got.record_space  = rsp.record_space;
			tracker.check_response(got);
		end
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: ends the run when no transaction completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("record_byte_ring_fifo test failed");
			$finish;
		end
	end

	// Presents one request, with random idle cycles ahead of it, and waits
	// until the transaction completes.
	task automatic send(rbrf_pkg::action_t act, logic [BYTE_W-1:0] din,
			logic [LEN_W-1:0] len);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.action  <= act;
		req.data_in <= din;
		req.length  <= len;
		do
			@(posedge clk);
		while (!req.ready);
		tracker.apply_request(act, din, len);
		items_sent++;
	endtask

	// Any action other than clear, with random fields.
	task automatic send_noise();
		send(rbrf_pkg::action_t'($urandom_range(6)), rand_byte(), rand_len());
	endtask

	// Writes one record, occasionally broken off or interleaved with
	// out-of-sequence actions.
	task automatic write_record();
		logic [LEN_W-1:0] len;
		case ($urandom_range(9))
			0:       len = rand_len();
			1:       len = LEN_W'(tracker.record_room());
			2:       len = LEN_W'(tracker.record_room() + 1);
			3:       len = LEN_W'($urandom_range(0, tracker.record_room()));
			default: len = LEN_W'($urandom_range(0, 24));
		endcase
		send(rbrf_pkg::ACT_WR_BEGIN, rand_byte(), len);
		while (tracker.mode == rbrf_pkg::MODE_WRITING) begin
			if ($urandom_range(39) == 0) begin
				if ($urandom_range(1) == 0)
					send(rbrf_pkg::ACT_CLEAR, rand_byte(), rand_len());
				else
					send_noise();
				break;
			end
			if ($urandom_range(19) == 0)
				send_noise();
			else
				send(rbrf_pkg::ACT_WR_BYTE, rand_byte(), rand_len());
		end
	endtask

	// Reads the head record, mostly to the end of what was asked for.
	task automatic read_record();
		logic [LEN_W-1:0] len;
		len = ($urandom_range(3) == 0) ? rand_len() : LEN_W'($urandom_range(0, 12));
		send(rbrf_pkg::ACT_RD_BEGIN, rand_byte(), len);
		while (tracker.mode == rbrf_pkg::MODE_READING) begin
			if ($urandom_range(39) == 0) begin
				send_noise();
				break;
			end
			if ($urandom_range(19) == 0)
				send_noise();
			else
				send(rbrf_pkg::ACT_RD_BYTE, rand_byte(), rand_len());
		end
	endtask

	// Random mix of record traffic, byte bursts and noise.
	task automatic random_traffic(int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				write_record();
			end else if (pick < 50) begin
				read_record();
			end else if (pick < 58) begin
				send(rbrf_pkg::ACT_SKIP, rand_byte(), rand_len());
			end else if (pick < 72) begin
				n = $urandom_range(1, 12);
				repeat (n)
					send(rbrf_pkg::ACT_PUT, rand_byte(), rand_len());
			end else if (pick < 84) begin
				n = $urandom_range(1, 12);
				repeat (n)
					send(rbrf_pkg::ACT_GET, rand_byte(), rand_len());
			end else if (pick < 85) begin
				// Fill the ring to the brim, then try once more.
				while (tracker.mode == rbrf_pkg::MODE_IDLE && tracker.committed() < DEPTH)
					send(rbrf_pkg::ACT_PUT, rand_byte(), rand_len());
				send(rbrf_pkg::ACT_PUT, rand_byte(), rand_len());
			end else if (pick < 87) begin
				// Drain the ring, then try once more.
				while (tracker.mode == rbrf_pkg::MODE_IDLE && tracker.committed() > 0)
					send(rbrf_pkg::ACT_GET, rand_byte(), rand_len());
				send(rbrf_pkg::ACT_GET, rand_byte(), rand_len());
			end else if (pick < 97) begin
				n = $urandom_range(1, 3);
				repeat (n)
					send(rbrf_pkg::action_t'($urandom_range(7)), rand_byte(), rand_len());
			end else begin
				send(rbrf_pkg::ACT_CLEAR, rand_byte(), rand_len());
			end
		end
	endtask

	// Main sequence: reset, directed cases, random phases, drain and verdict.
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		idle_pct    = 0;
		stall_pct   = 0;
		items_sent  = 0;
		req.valid   = 1'b0;
		req.action  = rbrf_pkg::ACT_PUT;
		req.data_in = '0;
		req.length  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring and actions out of sequence.
		send(rbrf_pkg::ACT_GET, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_RD_BEGIN, 8'h00, 16'h0005);
		send(rbrf_pkg::ACT_SKIP, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_WR_BYTE, 8'h12, 16'h0000);
		send(rbrf_pkg::ACT_RD_BYTE, 8'h00, 16'h0000);
		// Data extremes through plain byte mode.
		send(rbrf_pkg::ACT_PUT, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_PUT, 8'hFF, 16'hFFFF);
		send(rbrf_pkg::ACT_GET, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_GET, 8'h00, 16'h0000);
		// Record too large, and a zero-length record read with the largest length wanted.
		send(rbrf_pkg::ACT_WR_BEGIN, 8'h00, 16'hFFFF);
		send(rbrf_pkg::ACT_WR_BEGIN, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_RD_BEGIN, 8'h00, 16'hFFFF);
		// Record whose read asks for no bytes, with a put refused mid-write.
		send(rbrf_pkg::ACT_WR_BEGIN, 8'h00, 16'h0003);
		send(rbrf_pkg::ACT_PUT, 8'h77, 16'h0000);
		send(rbrf_pkg::ACT_WR_BYTE, 8'hA5, 16'h0000);
		send(rbrf_pkg::ACT_WR_BYTE, 8'h5A, 16'h0000);
		send(rbrf_pkg::ACT_WR_BYTE, 8'hFF, 16'h0000);
		send(rbrf_pkg::ACT_RD_BEGIN, 8'h00, 16'h0000);
		// Partial read of a record; the rest is dropped with the last byte.
		send(rbrf_pkg::ACT_WR_BEGIN, 8'h00, 16'h0002);
		send(rbrf_pkg::ACT_WR_BYTE, 8'h11, 16'h0000);
		send(rbrf_pkg::ACT_WR_BYTE, 8'h22, 16'h0000);
		send(rbrf_pkg::ACT_RD_BEGIN, 8'h00, 16'h0001);
		send(rbrf_pkg::ACT_RD_BYTE, 8'h00, 16'h0000);
		// Header that claims more bytes than the ring holds.
		send(rbrf_pkg::ACT_PUT, 8'h0A, 16'h0000);
		send(rbrf_pkg::ACT_PUT, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_PUT, 8'h33, 16'h0000);
		send(rbrf_pkg::ACT_RD_BEGIN, 8'h00, 16'hFFFF);
		send(rbrf_pkg::ACT_RD_BYTE, 8'h00, 16'h0000);
		send(rbrf_pkg::ACT_PUT, 8'h01, 16'h0000);
		send(rbrf_pkg::ACT_CLEAR, 8'h00, 16'h0000);

		// Random phases with different idling on either side.
		random_traffic(400);
		idle_pct  = 63;
		random_traffic(400);
		idle_pct  = 0;
		stall_pct = 63;
		random_traffic(400);
		idle_pct  = 16;
		stall_pct = 16;
		random_traffic(400);

		req.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("record_byte_ring_fifo test passed");
		else
			$display("record_byte_ring_fifo test failed");
		$finish;
	end

endmodule
